// ----- rtl/stma_pkg.sv -----
// shared types and constants for the sparse triplet matrix adder
// used by stma_ctrl, stma_dp and sparse_triplet_matrix_add
package stma_pkg;

   localparam int ROW_W = 16;
   localparam int COL_W = 16;
   localparam int VAL_W = 32;
   localparam int CSR_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int DATA_W = ROW_W + COL_W + VAL_W;

   localparam logic FUNC_ENTRY  = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_FIRST_ROWS  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FIRST_COLS  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SECOND_ROWS = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SECOND_COLS = 2'd3;

   typedef struct packed {
      logic [VAL_W-1:0] val;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } ent_type;

   typedef struct packed {
      logic accept;
      logic clear_run;
      logic scan_clr;
      logic rd_en;
      logic wr_hit;
      logic wr_new;
      logic load_hdr;
      logic load_ent;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic done;
      logic scan_more;
      logic shape_eq;
      logic out_free;
      logic cnt_zero;
      logic emit_last;
   } sts_type;

endpackage

// ----- rtl/stma_ctrl.sv -----
// controller state machine for the sparse triplet matrix adder
// depends on stma_pkg for command and status types
module stma_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_func,
   input  stma_pkg::sts_type sts,
   output stma_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEARCH  = 3'd1;
   localparam logic [2:0] ST_HEADER  = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == stma_pkg::FUNC_ENTRY) begin
                  cmd.accept = 1'b1;
                  state_in   = ST_SEARCH;
               end else if (sts.shape_eq) begin
                  state_in = ST_HEADER;
               end else begin
                  cmd.clear_run = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (sts.hit) begin
               cmd.wr_hit = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.done) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_en = sts.scan_more;
            end
         end
         ST_HEADER: begin
            if (sts.out_free) begin
               cmd.load_hdr = 1'b1;
               cmd.scan_clr = 1'b1;
               if (sts.cnt_zero) begin
                  cmd.clear_run = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_ent = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear_run = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/stma_dp.sv -----
// datapath: shape registers, entry table memory, scan counter and output register
// depends on stma_pkg for types, widths and register indexes
module stma_dp #(
   parameter int MAX_ENTRIES = 32,
   parameter int CNT_W       = 6,
   parameter int IDX_W       = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stma_pkg::cmd_type                  cmd,
   output stma_pkg::sts_type                  sts,
   input  logic [stma_pkg::DATA_W-1:0]        req_tdata,
   input  logic                               csr_we,
   input  logic [stma_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [stma_pkg::CSR_W-1:0]         csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [stma_pkg::DATA_W-1:0]        rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   logic [stma_pkg::CSR_W-1:0] first_rows_ff;
   logic [stma_pkg::CSR_W-1:0] first_cols_ff;
   logic [stma_pkg::CSR_W-1:0] second_rows_ff;
   logic [stma_pkg::CSR_W-1:0] second_cols_ff;

   stma_pkg::ent_type mem [MAX_ENTRIES];
   stma_pkg::ent_type item_ff;
   stma_pkg::ent_type rdata_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_vld_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              ovf_ff;
   logic              full;

   logic                        out_vld_ff;
   logic [stma_pkg::DATA_W-1:0] out_data_ff;
   logic                        out_ent_ff;
   logic                        out_drop_ff;
   logic                        out_last_ff;

   assign full = (count_ff == MAX_CNT);

   always_comb begin
      sts.hit       = rd_vld_ff && (rdata_ff.row == item_ff.row)
                      && (rdata_ff.col == item_ff.col);
      sts.scan_more = (scan_ff < count_ff);
      sts.done      = !sts.scan_more && !rd_vld_ff;
      sts.shape_eq  = (first_rows_ff == second_rows_ff) && (first_cols_ff == second_cols_ff);
      sts.out_free  = !out_vld_ff || rsp_tready;
      sts.cnt_zero  = (count_ff == '0);
      sts.emit_last = (scan_ff == count_ff);
   end

   // shape registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_rows_ff  <= stma_pkg::CSR_W'(1);
         first_cols_ff  <= stma_pkg::CSR_W'(1);
         second_rows_ff <= stma_pkg::CSR_W'(1);
         second_cols_ff <= stma_pkg::CSR_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            stma_pkg::REG_FIRST_ROWS:  first_rows_ff  <= csr_wdata;
            stma_pkg::REG_FIRST_COLS:  first_cols_ff  <= csr_wdata;
            stma_pkg::REG_SECOND_ROWS: second_rows_ff <= csr_wdata;
            stma_pkg::REG_SECOND_COLS: second_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // entry table
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[scan_ff[IDX_W-1:0]];
      end
      if (cmd.wr_hit) begin
         mem[rd_idx_ff] <= '{val: rdata_ff.val + item_ff.val,
                             col: rdata_ff.col, row: rdata_ff.row};
      end else if (cmd.wr_new && !full) begin
         mem[count_ff[IDX_W-1:0]] <= item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= stma_pkg::ent_type'(req_tdata);
      end
      if (cmd.rd_en) begin
         rd_idx_ff <= scan_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         scan_ff   <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.accept || cmd.scan_clr) begin
            scan_ff <= '0;
         end else if (cmd.rd_en) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         if (cmd.clear_run) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else if (cmd.wr_new) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.load_hdr || cmd.load_ent) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_hdr) begin
         out_data_ff <= {{(stma_pkg::VAL_W-CNT_W){1'b0}}, count_ff,
                         first_cols_ff, first_rows_ff};
         out_ent_ff  <= 1'b0;
         out_drop_ff <= ovf_ff;
         out_last_ff <= (count_ff == '0);
      end else if (cmd.load_ent) begin
         out_data_ff <= rdata_ff;
         out_ent_ff  <= 1'b1;
         out_drop_ff <= ovf_ff;
         out_last_ff <= (scan_ff == count_ff);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_drop_ff, out_ent_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count above table size");

   a_hit_excl_done: assert property (@(posedge clock) disable iff (reset)
      !(sts.hit && sts.done))
      else $error("search reports hit and miss together");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_run |=> (count_ff == '0) && !ovf_ff)
      else $error("run state not cleared");

   a_full_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_new && full |=> ovf_ff && (count_ff == MAX_CNT))
      else $error("insert into full table not flagged");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_hdr || cmd.load_ent) |-> (!out_vld_ff || rsp_tready))
      else $error("output register overwritten while held");
`endif

endmodule

// ----- rtl/sparse_triplet_matrix_add.sv -----
// An entry item (tuser low) is searched against the stored positions one
// per cycle through the table's registered read port; ready stays low
// meanwhile. A finish item whose two shapes agree gives a header as soon
// as the output register is free, then, after a read state, one stored
// entry per cycle while the output register is free, the final one with
// tlast; on a shape mismatch it gives nothing and the run is cleared.
// Shape registers must be written while the block is idle.
// top level of the sparse triplet matrix adder
// depends on stma_pkg, stma_ctrl and stma_dp
module sparse_triplet_matrix_add #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [stma_pkg::DATA_W-1:0]     req_tdata,   // row, col, value
   input  logic                            req_tuser,   // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [stma_pkg::DATA_W-1:0]     rsp_tdata,   // out_row, out_col, out_value
   output logic [1:0]                      rsp_tuser,   // is_entry, dropped
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [stma_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [stma_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   stma_pkg::cmd_type cmd;
   stma_pkg::sts_type sts;

   stma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   stma_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for sparse_triplet_matrix_add: directed table then random runs,
// finishes checked against an in-bench model of the coordinate table and shapes or a fixed header
// depends on stma_pkg and the sparse_triplet_matrix_add rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_ENTRIES = 32;
   localparam int SETTLE = MAX_ENTRIES + 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 130;
   localparam int PLAN_LEN = 29;

   typedef struct {
      logic        is_entry;
      logic [15:0] row;
      logic [15:0] col;
      logic [31:0] value;
      logic        dropped;
      logic        is_last;
   } sum_item_type;

   typedef enum logic {OP_CSR, OP_ITEM} step_op_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HEADER} check_type;

   typedef struct {
      step_op_type                     op;
      logic [stma_pkg::CSR_ADDR_W-1:0] addr;
      logic [stma_pkg::CSR_W-1:0]      wdata;
      logic                            func;
      logic [15:0]                     row;
      logic [15:0]                     col;
      logic [31:0]                     value;
      check_type                       chk;
      logic [15:0]                     hdr_rows;
      logic [15:0]                     hdr_cols;
   } step_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [stma_pkg::DATA_W-1:0]     req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [stma_pkg::DATA_W-1:0]     rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we;
   logic [stma_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [stma_pkg::CSR_W-1:0]      csr_wdata;

   // shape registers and coordinate table as the block should hold them
   logic [15:0] shape_rows1, shape_cols1, shape_rows2, shape_cols2;
   logic [15:0] tab_row [MAX_ENTRIES];
   logic [15:0] tab_col [MAX_ENTRIES];
   logic [31:0] tab_sum [MAX_ENTRIES];
   int          tab_count;
   logic        tab_overflow;

   sum_item_type predicted_sums [$];
   sum_item_type step_sums [$];
   step_type     plan [PLAN_LEN];

   int   errors;
   int   items_sent;
   int   finishes_sent;
   int   results_seen;
   int   overflow_runs;
   int   stall_left;
   int   quiet_cycles;
   bit   idling;
   bit   items_since_write;

   sparse_triplet_matrix_add #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic add_sum_item(input logic is_entry, input logic [15:0] row,
                               input logic [15:0] col, input logic [31:0] value,
                               input logic is_last);
      sum_item_type s;
      s.is_entry = is_entry;
      s.row = row;
      s.col = col;
      s.value = value;
      s.dropped = tab_overflow;
      s.is_last = is_last;
      step_sums.push_back(s);
   endtask

   // one accepted item: update the table, leave any results in step_sums
   task automatic matrix_sum_step(input logic func, input logic [15:0] row,
                                  input logic [15:0] col, input logic [31:0] value);
      bit hit;
      hit = 0;
      step_sums.delete();
      if (func == stma_pkg::FUNC_ENTRY) begin
         for (int i = 0; i < tab_count; i++) begin
            if (!hit && tab_row[i] == row && tab_col[i] == col) begin
               tab_sum[i] = tab_sum[i] + value;
               hit = 1;
            end
         end
         if (!hit) begin
            if (tab_count < MAX_ENTRIES) begin
               tab_row[tab_count] = row;
               tab_col[tab_count] = col;
               tab_sum[tab_count] = value;
               tab_count++;
            end else begin
               tab_overflow = 1'b1;
            end
         end
      end else begin
         if (shape_rows1 == shape_rows2 && shape_cols1 == shape_cols2) begin
            add_sum_item(1'b0, shape_rows1, shape_cols1, tab_count, tab_count == 0);
            for (int i = 0; i < tab_count; i++)
               add_sum_item(1'b1, tab_row[i], tab_col[i], tab_sum[i], i == tab_count - 1);
         end
         tab_count = 0;
         tab_overflow = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, want %h (result %0d)", what, got, want,
               results_seen);
      errors++;
   endtask

   task automatic check_sum_result(input sum_item_type got);
      sum_item_type want;
      if (predicted_sums.size() == 0) begin
         report_mismatch("unexpected result value", got.value, 32'h0);
      end else begin
         want = predicted_sums.pop_front();
         if (got.is_entry !== want.is_entry)
            report_mismatch("is_entry", 32'(got.is_entry), 32'(want.is_entry));
         if (got.row !== want.row) report_mismatch("out_row", 32'(got.row), 32'(want.row));
         if (got.col !== want.col) report_mismatch("out_col", 32'(got.col), 32'(want.col));
         if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
         if (got.dropped !== want.dropped)
            report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
         if (got.is_last !== want.is_last)
            report_mismatch("tlast", 32'(got.is_last), 32'(want.is_last));
      end
      results_seen++;
   endtask

   task automatic send_item(input logic func, input logic [15:0] row, input logic [15:0] col,
                            input logic [31:0] value, input check_type chk,
                            input logic [15:0] hdr_rows, input logic [15:0] hdr_cols);
      sum_item_type hdr;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {value, col, row};
      do @(posedge clock); while (!req_tready);
      matrix_sum_step(func, row, col, value);
      case (chk)
         CHK_MODEL: begin
            foreach (step_sums[i]) predicted_sums.push_back(step_sums[i]);
         end
         CHK_HEADER: begin
            hdr.is_entry = 1'b0;
            hdr.row = hdr_rows;
            hdr.col = hdr_cols;
            hdr.value = 32'h0;
            hdr.dropped = 1'b0;
            hdr.is_last = 1'b1;
            predicted_sums.push_back(hdr);
         end
         default: ;
      endcase
      items_sent++;
      items_since_write = 1;
      if (func == stma_pkg::FUNC_FINISH) finishes_sent++;
   endtask

   task automatic write_reg(input logic [stma_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [stma_pkg::CSR_W-1:0] data);
      req_tvalid <= 1'b0;
      if (items_since_write) begin
         while (predicted_sums.size() != 0) @(posedge clock);
         repeat (SETTLE) @(posedge clock);
         items_since_write = 0;
      end
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         stma_pkg::REG_FIRST_ROWS:  shape_rows1 = data;
         stma_pkg::REG_FIRST_COLS:  shape_cols1 = data;
         stma_pkg::REG_SECOND_ROWS: shape_rows2 = data;
         stma_pkg::REG_SECOND_COLS: shape_cols2 = data;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_index(input logic [15:0] limit);
      if (limit == 0 || $urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, limit > 8 ? 7 : limit - 1));
   endfunction

   // result side: check, random stalls, watchdog
   always @(posedge clock) begin
      sum_item_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.row = rsp_tdata[15:0];
            got.col = rsp_tdata[31:16];
            got.value = rsp_tdata[63:32];
            got.is_entry = rsp_tuser[0];
            got.dropped = rsp_tuser[1];
            got.is_last = rsp_tlast;
            check_sum_result(got);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [15:0] rows, cols, r, c;
      logic [15:0] run_rows [$];
      logic [15:0] run_cols [$];
      int          n, runs, k, total;
      bit          overflow_done, quiet;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= stma_pkg::FUNC_ENTRY;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= stma_pkg::REG_FIRST_ROWS;
      csr_wdata <= '0;
      shape_rows1 = 16'd1;
      shape_cols1 = 16'd1;
      shape_rows2 = 16'd1;
      shape_cols2 = 16'd1;
      tab_count = 0;
      tab_overflow = 1'b0;
      errors = 0;
      items_sent = 0;
      finishes_sent = 0;
      results_seen = 0;
      overflow_runs = 0;
      items_since_write = 0;
      overflow_done = 0;
      quiet = 0;
      idling = 1;

      plan = '{
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_HEADER, 16'd1, 16'd1},
         '{OP_CSR, stma_pkg::REG_FIRST_ROWS, 16'hffff, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_FIRST_COLS, 16'hffff, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_SECOND_ROWS, 16'hffff, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_SECOND_COLS, 16'hffff, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h7fffffff, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'hffff, 16'hffff, 32'h80000000, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h1, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'hffff, 16'h0, 32'hffffffff, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'hffff, 32'h0, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'hffff, 16'hffff, 32'hffffffff, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'hffff, 16'hffff, 32'hffffffff, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_HEADER, 16'hffff, 16'hffff},
         '{OP_CSR, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'd5, 16'd5, 32'h1234, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'd5, 16'd5, 32'hffffffff, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_SECOND_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_FIRST_COLS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_SECOND_COLS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_HEADER, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'd3, 16'd9, 32'd42, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_MODEL, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_FIRST_COLS, 16'd1, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_ENTRY,
           16'd1, 16'd2, 32'd3, CHK_MODEL, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_CSR, stma_pkg::REG_SECOND_COLS, 16'd1, stma_pkg::FUNC_ENTRY,
           16'h0, 16'h0, 32'h0, CHK_NONE, 16'h0, 16'h0},
         '{OP_ITEM, stma_pkg::REG_FIRST_ROWS, 16'h0, stma_pkg::FUNC_FINISH,
           16'h0, 16'h0, 32'h0, CHK_HEADER, 16'h0, 16'd1}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].op == OP_CSR)
            write_reg(plan[i].addr, plan[i].wdata);
         else
            send_item(plan[i].func, plan[i].row, plan[i].col, plan[i].value, plan[i].chk,
                      plan[i].hdr_rows, plan[i].hdr_cols);
      end

      total = items_sent + RANDOM_ITEMS;
      while (items_sent < total) begin
         // new shape setting: mostly small matching shapes, some extremes and mismatches
         k = $urandom_range(0, 9);
         if (k == 0) begin
            rows = 16'($urandom_range(0, 65535));
            cols = 16'($urandom_range(0, 65535));
         end else if (k == 1) begin
            rows = 16'hffff;
            cols = $urandom_range(0, 1) ? 16'hffff : 16'h0;
         end else begin
            rows = 16'($urandom_range(1, 8));
            cols = 16'($urandom_range(1, 8));
         end
         write_reg(stma_pkg::REG_FIRST_ROWS, rows);
         write_reg(stma_pkg::REG_FIRST_COLS, cols);
         if (k == 2 && $urandom_range(0, 1) == 0) begin
            write_reg(stma_pkg::REG_SECOND_ROWS, rows ^ 16'(1 << $urandom_range(0, 15)));
            write_reg(stma_pkg::REG_SECOND_COLS, cols);
         end else if (k == 3 && $urandom_range(0, 1) == 0) begin
            write_reg(stma_pkg::REG_SECOND_ROWS, rows);
            write_reg(stma_pkg::REG_SECOND_COLS, cols ^ 16'(1 << $urandom_range(0, 15)));
         end else begin
            write_reg(stma_pkg::REG_SECOND_ROWS, rows);
            write_reg(stma_pkg::REG_SECOND_COLS, cols);
         end

         runs = $urandom_range(1, 3);
         for (int run = 0; run < runs && items_sent < total; run++) begin
            quiet = items_sent >= total - 30;
            idling = !quiet && $urandom_range(0, 3) != 0;
            run_rows.delete();
            run_cols.delete();
            if (!overflow_done || $urandom_range(0, 9) == 0) begin
               // fill past the table size, then hit stored positions again
               overflow_done = 1;
               overflow_runs++;
               n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 6);
               for (int i = 0; i < n; i++) begin
                  r = 16'(i);
                  c = 16'($urandom_range(0, 65535));
                  run_rows.push_back(r);
                  run_cols.push_back(c);
                  send_item(stma_pkg::FUNC_ENTRY, r, c, $urandom, CHK_MODEL, 16'h0, 16'h0);
               end
               for (int i = 0; i < 3; i++) begin
                  k = $urandom_range(0, MAX_ENTRIES - 1);
                  send_item(stma_pkg::FUNC_ENTRY, run_rows[k], run_cols[k], $urandom,
                            CHK_MODEL, 16'h0, 16'h0);
               end
            end else begin
               n = $urandom_range(0, 10);
               for (int i = 0; i < n; i++) begin
                  if (run_rows.size() != 0 && $urandom_range(0, 2) == 0) begin
                     k = $urandom_range(0, run_rows.size() - 1);
                     r = run_rows[k];
                     c = run_cols[k];
                  end else begin
                     r = pick_index(rows);
                     c = pick_index(cols);
                     run_rows.push_back(r);
                     run_cols.push_back(c);
                  end
                  send_item(stma_pkg::FUNC_ENTRY, r, c, $urandom, CHK_MODEL, 16'h0, 16'h0);
               end
            end
            send_item(stma_pkg::FUNC_FINISH, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), $urandom, CHK_MODEL, 16'h0, 16'h0);
         end
      end

      idling = 0;
      req_tvalid <= 1'b0;
      while (predicted_sums.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d items with %0d finishes, %0d results checked", items_sent,
               finishes_sent, results_seen);
      $display("%0d runs went past the table size, %0d mismatches", overflow_runs, errors);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
